// File: hw/rtl/tspa_pkg.sv
package tspa_pkg;

  // Field widths
  localparam int FUNC_W    = 3;
  localparam int SLOT_W    = 10;
  localparam int STATUS_W  = 2;
  localparam int ORG_W     = 17;
  localparam int POOL_W    = 11;
  localparam int SIDE_W    = 6;
  localparam int DIM_W     = 13;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = SLOT_W + DIM_W;
  localparam int STEP_W    = $clog2(SLOT_W);

  // Pool depth default and register reset values
  localparam int MAX_SLOTS_DEF    = 1024;
  localparam int RESET_POOL_ITEMS = 1024;
  localparam logic [POOL_W-1:0] RESET_POOL_REG = POOL_W'(RESET_POOL_ITEMS);
  localparam logic [SIDE_W-1:0] RESET_SIDE     = SIDE_W'(32);
  localparam logic [DIM_W-1:0]  RESET_DIM      = DIM_W'(64);

  localparam logic [ORG_W-1:0] ORG_MAX = {ORG_W{1'b1}};

  // Request functions
  localparam logic [FUNC_W-1:0] FUNC_ACQUIRE = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOCATE  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_INIT    = 3'd4;

  // Response status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_HELD = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POOL_ITEMS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_SIDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_DIM   = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SLOT_W-1:0] slot;
  } tspa_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   granted_slot;
    logic [ORG_W-1:0]    origin_x;
    logic [ORG_W-1:0]    origin_y;
    logic                all_free;
  } tspa_rsp_t;

  // Origin unit handshake
  typedef struct packed {
    logic              start;
    logic [SLOT_W-1:0] slot;
    logic [SIDE_W-1:0] side;
    logic [DIM_W-1:0]  dim;
  } tspa_org_req_t;

  typedef struct packed {
    logic             done;
    logic [ORG_W-1:0] x;
    logic [ORG_W-1:0] y;
  } tspa_org_rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_POP,
    S_REL_CHK,
    S_COPY_RD,
    S_COPY_WR,
    S_ORIGIN,
    S_RESULT
  } tspa_state_t;

  typedef enum logic [2:0] {
    O_IDLE,
    O_DIV,
    O_MULQ,
    O_MULR,
    O_DONE
  } tspa_org_state_t;

endpackage

// File: hw/rtl/tspa_ram.sv
module tspa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/tspa_origin.sv
module tspa_origin (
  input  logic                   clk,
  input  logic                   rst,
  input  tspa_pkg::tspa_org_req_t req,
  output tspa_pkg::tspa_org_rsp_t rsp
);

  tspa_pkg::tspa_org_state_t ostate, ostate_next;

  logic [tspa_pkg::STEP_W-1:0] step, step_next;
  logic [tspa_pkg::SLOT_W-1:0] dvd, dvd_next;
  logic [tspa_pkg::SLOT_W-1:0] quot, quot_next;
  logic [tspa_pkg::SIDE_W-1:0] rem, rem_next;
  logic [tspa_pkg::SIDE_W-1:0] side, side_next;
  logic [tspa_pkg::DIM_W-1:0]  dim, dim_next;
  logic [tspa_pkg::ORG_W-1:0]  ox, ox_next;
  logic [tspa_pkg::ORG_W-1:0]  oy, oy_next;

  logic [tspa_pkg::SIDE_W:0]   trial;
  logic                        fits;
  logic [tspa_pkg::SLOT_W-1:0] mul_a;
  logic [tspa_pkg::PROD_W-1:0] prod;
  logic [tspa_pkg::ORG_W-1:0]  prod_sat;

  // restoring divider step: one quotient bit per cycle
  assign trial = {rem, dvd[tspa_pkg::SLOT_W-1]};
  assign fits  = (trial >= {1'b0, side});

  // shared multiplier: quotient first, then remainder
  assign mul_a    = (ostate == tspa_pkg::O_MULR) ? tspa_pkg::SLOT_W'(rem) : quot;
  assign prod     = tspa_pkg::PROD_W'(mul_a) * tspa_pkg::PROD_W'(dim);
  assign prod_sat = (prod > tspa_pkg::PROD_W'(tspa_pkg::ORG_MAX)) ?
                    tspa_pkg::ORG_MAX : tspa_pkg::ORG_W'(prod);

  // sequencer
  always_comb begin
    ostate_next = ostate;
    step_next   = step;
    dvd_next    = dvd;
    quot_next   = quot;
    rem_next    = rem;
    side_next   = side;
    dim_next    = dim;
    ox_next     = ox;
    oy_next     = oy;
    rsp.done    = 1'b0;
    rsp.x       = ox;
    rsp.y       = oy;
    case (ostate)
      tspa_pkg::O_IDLE: begin
        if (req.start) begin
          dvd_next    = req.slot;
          side_next   = req.side;
          dim_next    = req.dim;
          rem_next    = '0;
          quot_next   = '0;
          step_next   = '0;
          ostate_next = tspa_pkg::O_DIV;
        end
      end
      tspa_pkg::O_DIV: begin
        rem_next  = fits ? tspa_pkg::SIDE_W'(trial - {1'b0, side})
                         : trial[tspa_pkg::SIDE_W-1:0];
        quot_next = {quot[tspa_pkg::SLOT_W-2:0], fits};
        dvd_next  = dvd << 1;
        step_next = step + tspa_pkg::STEP_W'(1);
        if (step == tspa_pkg::STEP_W'(tspa_pkg::SLOT_W - 1)) begin
          ostate_next = tspa_pkg::O_MULQ;
        end
      end
      tspa_pkg::O_MULQ: begin
        ox_next     = prod_sat;
        ostate_next = tspa_pkg::O_MULR;
      end
      tspa_pkg::O_MULR: begin
        oy_next     = prod_sat;
        ostate_next = tspa_pkg::O_DONE;
      end
      tspa_pkg::O_DONE: begin
        rsp.done    = 1'b1;
        ostate_next = tspa_pkg::O_IDLE;
      end
      default: begin
        ostate_next = tspa_pkg::O_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ostate <= tspa_pkg::O_IDLE;
    end else begin
      ostate <= ostate_next;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    step <= step_next;
    dvd  <= dvd_next;
    quot <= quot_next;
    rem  <= rem_next;
    side <= side_next;
    dim  <= dim_next;
    ox   <= ox_next;
    oy   <= oy_next;
  end

endmodule

// File: hw/rtl/tile_slot_pool_allocator_core.sv
// Tile slot pool allocator: hands out square tiles of one atlas from a slot pool.
// Request channel (req_valid/req_ready, req): func and slot. Response channel
// (rsp_valid/rsp_ready, rsp): status, granted_slot, origin_x/y, all_free.
// Exactly one response per request, in request order.
// Config: cfg_we/cfg_index/cfg_data write pool_items, atlas_side, tile_dim; only
// write while no request is in flight.
// One request at a time. Acquire and locate get their origins from a divider
// that makes one quotient bit per cycle and one multiplier used twice. Quarantine
// moves go entry by entry over the RAM read port, via a read and a write state.
// Reset: all MAX_SLOTS held-mark RAM entries are swept clear, with req_ready
// low; config writes are taken meanwhile. The free stack needs no sweep: entries
// below the low-water mark read as their init value.
// Stall: a finished response sits in the output register; a new request is
// accepted meanwhile, but its response waits until the old one is taken.
module tile_slot_pool_allocator_core #(
  parameter int MAX_SLOTS = tspa_pkg::MAX_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  tspa_pkg::tspa_req_t                req,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output tspa_pkg::tspa_rsp_t                rsp,
  input  logic                               cfg_we,
  input  logic [tspa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tspa_pkg::CFG_W-1:0]         cfg_data
);

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam logic [CW-1:0] POOL_CAP = CW'(MAX_SLOTS);
  localparam logic [CW-1:0] RESET_POOL =
    (tspa_pkg::RESET_POOL_ITEMS > MAX_SLOTS) ? CW'(MAX_SLOTS)
                                             : CW'(tspa_pkg::RESET_POOL_ITEMS);

  // configuration registers
  logic [tspa_pkg::POOL_W-1:0] pool_items;
  logic [tspa_pkg::SIDE_W-1:0] atlas_side;
  logic [tspa_pkg::DIM_W-1:0]  tile_dim;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_items <= tspa_pkg::RESET_POOL_REG;
      atlas_side <= tspa_pkg::RESET_SIDE;
      tile_dim   <= tspa_pkg::RESET_DIM;
    end else if (cfg_we) begin
      case (cfg_index)
        tspa_pkg::REG_POOL_ITEMS: pool_items <= cfg_data[tspa_pkg::POOL_W-1:0];
        tspa_pkg::REG_ATLAS_SIDE: atlas_side <= cfg_data[tspa_pkg::SIDE_W-1:0];
        tspa_pkg::REG_TILE_DIM:   tile_dim   <= cfg_data[tspa_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  tspa_pkg::tspa_state_t state, state_next;

  logic [CW-1:0] free_count, free_count_next;
  logic [CW-1:0] low_mark, low_mark_next;
  logic [CW-1:0] fill_size, fill_size_next;
  logic [CW-1:0] qcount, qcount_next;
  logic [CW-1:0] copy_idx, copy_idx_next;
  logic [AW-1:0] clr_idx, clr_idx_next;
  logic          clr_reply, clr_reply_next;
  logic          copy_acq, copy_acq_next;
  logic          rsp_valid_next;

  tspa_pkg::tspa_req_t req_q, req_q_next;
  tspa_pkg::tspa_rsp_t res, res_next;
  tspa_pkg::tspa_rsp_t rsp_next;

  // memory ports
  logic                        stack_we;
  logic [tspa_pkg::SLOT_W-1:0] stack_rdata;
  logic                        held_we;
  logic [AW-1:0]               held_waddr;
  logic                        held_wdata;
  logic                        held_rdata;
  logic                        quar_we;
  logic [tspa_pkg::SLOT_W-1:0] quar_rdata;

  tspa_pkg::tspa_org_req_t org_req;
  tspa_pkg::tspa_org_rsp_t org_rsp;
  logic                    org_start;

  logic [CW-1:0]               n_pool;
  logic [CW-1:0]               fc_dec;
  logic                        slot_ok;
  logic [tspa_pkg::SLOT_W-1:0] top_init;
  logic [tspa_pkg::SLOT_W-1:0] pop_slot;
  logic                        copy_more;

  // working pool size
  always_comb begin
    if (32'(pool_items) > MAX_SLOTS) begin
      n_pool = POOL_CAP;
    end else begin
      n_pool = CW'(pool_items);
    end
  end

  assign fc_dec  = free_count - CW'(1);
  assign slot_ok = (32'(req_q.slot) < 32'(n_pool));

  // stack entries below the low-water mark still hold their init value
  assign top_init  = tspa_pkg::SLOT_W'(fill_size - CW'(1) - fc_dec);
  assign pop_slot  = (fc_dec < low_mark) ? top_init : stack_rdata;
  assign copy_more = (copy_idx < qcount) && (free_count < POOL_CAP);

  assign org_req.start = org_start;
  assign org_req.slot  = (state == tspa_pkg::S_POP) ? pop_slot : req_q.slot;
  assign org_req.side  = (atlas_side == '0) ? tspa_pkg::SIDE_W'(1) : atlas_side;
  assign org_req.dim   = tile_dim;

  // sequencer
  always_comb begin
    state_next      = state;
    free_count_next = free_count;
    low_mark_next   = low_mark;
    fill_size_next  = fill_size;
    qcount_next     = qcount;
    copy_idx_next   = copy_idx;
    clr_idx_next    = clr_idx;
    clr_reply_next  = clr_reply;
    copy_acq_next   = copy_acq;
    req_q_next      = req_q;
    res_next        = res;
    rsp_next        = rsp;
    rsp_valid_next  = rsp_valid && !rsp_ready;
    req_ready       = 1'b0;
    stack_we        = 1'b0;
    held_we         = 1'b0;
    held_waddr      = AW'(req_q.slot);
    held_wdata      = 1'b0;
    quar_we         = 1'b0;
    org_start       = 1'b0;

    case (state)
      tspa_pkg::S_CLEAR: begin
        held_we      = 1'b1;
        held_waddr   = clr_idx;
        clr_idx_next = clr_idx + AW'(1);
        if (clr_idx == AW'(MAX_SLOTS - 1)) begin
          clr_idx_next   = '0;
          clr_reply_next = 1'b0;
          state_next     = clr_reply ? tspa_pkg::S_RESULT : tspa_pkg::S_IDLE;
        end
      end
      tspa_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          req_q_next = req;
          res_next   = '0;
          state_next = tspa_pkg::S_EXEC;
        end
      end
      tspa_pkg::S_EXEC: begin
        case (req_q.func)
          tspa_pkg::FUNC_ACQUIRE: begin
            if (free_count != '0) begin
              state_next = tspa_pkg::S_POP;
            end else if (qcount != '0) begin
              copy_idx_next = '0;
              copy_acq_next = 1'b1;
              state_next    = tspa_pkg::S_COPY_RD;
            end else begin
              res_next.status = tspa_pkg::STATUS_NO_FREE;
              state_next      = tspa_pkg::S_RESULT;
            end
          end
          tspa_pkg::FUNC_RELEASE: begin
            if (!slot_ok) begin
              res_next.status = tspa_pkg::STATUS_RANGE;
              state_next      = tspa_pkg::S_RESULT;
            end else begin
              state_next = tspa_pkg::S_REL_CHK;
            end
          end
          tspa_pkg::FUNC_LOCATE: begin
            res_next.granted_slot = req_q.slot;
            if (!slot_ok) begin
              res_next.status = tspa_pkg::STATUS_RANGE;
              state_next      = tspa_pkg::S_RESULT;
            end else begin
              org_start  = 1'b1;
              state_next = tspa_pkg::S_ORIGIN;
            end
          end
          tspa_pkg::FUNC_FLUSH: begin
            copy_idx_next = '0;
            copy_acq_next = 1'b0;
            state_next    = tspa_pkg::S_COPY_RD;
          end
          tspa_pkg::FUNC_INIT: begin
            free_count_next   = n_pool;
            low_mark_next     = n_pool;
            fill_size_next    = n_pool;
            qcount_next       = '0;
            clr_idx_next      = '0;
            clr_reply_next    = 1'b1;
            res_next.all_free = 1'b1;
            state_next        = tspa_pkg::S_CLEAR;
          end
          default: begin
            state_next = tspa_pkg::S_RESULT;
          end
        endcase
      end
      tspa_pkg::S_POP: begin
        free_count_next = fc_dec;
        if (fc_dec < low_mark) begin
          low_mark_next = fc_dec;
        end
        if (32'(pop_slot) < MAX_SLOTS) begin
          held_we    = 1'b1;
          held_waddr = AW'(pop_slot);
          held_wdata = 1'b1;
        end
        res_next.granted_slot = pop_slot;
        org_start             = 1'b1;
        state_next            = tspa_pkg::S_ORIGIN;
      end
      tspa_pkg::S_REL_CHK: begin
        if (!held_rdata) begin
          res_next.status = tspa_pkg::STATUS_NOT_HELD;
        end else begin
          held_we = 1'b1;
          if (qcount < POOL_CAP) begin
            quar_we     = 1'b1;
            qcount_next = qcount + CW'(1);
          end
        end
        state_next = tspa_pkg::S_RESULT;
      end
      tspa_pkg::S_COPY_RD: begin
        if (copy_more) begin
          state_next = tspa_pkg::S_COPY_WR;
        end else begin
          qcount_next = '0;
          if (copy_acq) begin
            state_next = tspa_pkg::S_EXEC;
          end else begin
            res_next.all_free = (free_count == n_pool);
            state_next        = tspa_pkg::S_RESULT;
          end
        end
      end
      tspa_pkg::S_COPY_WR: begin
        stack_we        = 1'b1;
        free_count_next = free_count + CW'(1);
        copy_idx_next   = copy_idx + CW'(1);
        state_next      = tspa_pkg::S_COPY_RD;
      end
      tspa_pkg::S_ORIGIN: begin
        if (org_rsp.done) begin
          res_next.origin_x = org_rsp.x;
          res_next.origin_y = org_rsp.y;
          state_next        = tspa_pkg::S_RESULT;
        end
      end
      tspa_pkg::S_RESULT: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_next       = res;
          rsp_valid_next = 1'b1;
          state_next     = tspa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tspa_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tspa_pkg::S_CLEAR;
      free_count <= RESET_POOL;
      low_mark   <= RESET_POOL;
      fill_size  <= RESET_POOL;
      qcount     <= '0;
      copy_idx   <= '0;
      clr_idx    <= '0;
      clr_reply  <= 1'b0;
      copy_acq   <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      free_count <= free_count_next;
      low_mark   <= low_mark_next;
      fill_size  <= fill_size_next;
      qcount     <= qcount_next;
      copy_idx   <= copy_idx_next;
      clr_idx    <= clr_idx_next;
      clr_reply  <= clr_reply_next;
      copy_acq   <= copy_acq_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    req_q <= req_q_next;
    res   <= res_next;
    rsp   <= rsp_next;
  end

  // free stack: pop reads top, quarantine moves push
  tspa_ram #(
    .WIDTH (tspa_pkg::SLOT_W),
    .DEPTH (MAX_SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (AW'(free_count)),
    .wdata (quar_rdata),
    .raddr (AW'(fc_dec)),
    .rdata (stack_rdata)
  );

  // quarantine list
  tspa_ram #(
    .WIDTH (tspa_pkg::SLOT_W),
    .DEPTH (MAX_SLOTS)
  ) u_quar_ram (
    .clk   (clk),
    .we    (quar_we),
    .waddr (AW'(qcount)),
    .wdata (req_q.slot),
    .raddr (AW'(copy_idx)),
    .rdata (quar_rdata)
  );

  // held marks
  tspa_ram #(
    .WIDTH (1),
    .DEPTH (MAX_SLOTS)
  ) u_held_ram (
    .clk   (clk),
    .we    (held_we),
    .waddr (held_waddr),
    .wdata (held_wdata),
    .raddr (AW'(req_q.slot)),
    .rdata (held_rdata)
  );

  tspa_origin u_origin (
    .clk (clk),
    .rst (rst),
    .req (org_req),
    .rsp (org_rsp)
  );

`ifndef SYNTHESIS
  a_counts_bound: assert property (@(posedge clk) disable iff (rst)
    (free_count <= POOL_CAP) && (qcount <= POOL_CAP))
    else $error("free or quarantine count above pool capacity");

  a_low_mark: assert property (@(posedge clk) disable iff (rst)
    (low_mark <= free_count) && (low_mark <= fill_size))
    else $error("low-water mark above stack depth or fill size");

  a_rsp_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == tspa_pkg::S_RESULT))
    else $error("response raised outside result state");

  a_copy_drains: assert property (@(posedge clk) disable iff (rst)
    (state == tspa_pkg::S_COPY_RD && !copy_more) |=> (qcount == '0))
    else $error("quarantine not emptied after move");
`endif

endmodule
